### rtl/core/gnz_pkg.sv
package gnz_pkg;

   localparam int TAB_BITS   = 8;
   localparam int TAB_DEPTH  = 1 << TAB_BITS;
   localparam int FRAC_BITS  = 16;
   localparam int GRAD_BITS  = 16;
   localparam int FADE_BITS  = 16;
   localparam int DOT_BITS   = 20;
   localparam int OUT_BITS   = 18;
   localparam int COORD_BITS = 32;

   localparam logic [1:0] OP_EVAL = 2'd0;
   localparam logic [1:0] OP_PERM = 2'd1;
   localparam logic [1:0] OP_GRAD = 2'd2;

   // fade polynomial offsets in signed Q5.16 and Q22.16
   localparam logic signed [21:0] FADE_P_OFS = 22'sd983040;
   localparam logic signed [38:0] FADE_Q_OFS = 39'sd655360;

   localparam logic signed [DOT_BITS-1:0] OUT_MAX = DOT_BITS'(131071);
   localparam logic signed [DOT_BITS-1:0] OUT_MIN = -DOT_BITS'(131072);

   typedef struct packed {
      logic signed [GRAD_BITS-1:0] gx;
      logic signed [GRAD_BITS-1:0] gy;
   } grad_type;

   typedef struct packed {
      logic [1:0]          op;
      logic [TAB_BITS-1:0] idx;
      logic [TAB_BITS-1:0] perm;
      grad_type            grad;
   } load_type;

endpackage

### rtl/core/gnz_fade.sv
module gnz_fade
   import gnz_pkg::*;
(
   input  logic                 clock,
   input  logic                 adv,
   input  logic [FADE_BITS-1:0] t,
   output logic [FADE_BITS-1:0] u
);

   logic signed [21:0] p_w;
   logic signed [38:0] tp_w;
   logic signed [38:0] q_w;
   logic [35:0]        u_w;

   logic [31:0]          tt_ff;
   logic signed [38:0]   tp_ff;
   logic [FADE_BITS-1:0] t1_ff;
   logic [31:0]          c_ff;
   logic [19:0]          q_ff;
   logic [FADE_BITS-1:0] u_ff;

   always_comb begin
      p_w  = $signed({6'd0, t}) * 22'sd6 - FADE_P_OFS;
      tp_w = $signed({23'd0, t}) * 39'(p_w);
      q_w  = (tp_ff >>> FADE_BITS) + FADE_Q_OFS;
      u_w  = c_ff[31:16] * q_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tt_ff <= t * t;
         tp_ff <= tp_w;
         t1_ff <= t;
         c_ff  <= tt_ff[31:16] * t1_ff;
         q_ff  <= q_w[19:0];
         u_ff  <= u_w[31:16];
      end
   end

   assign u = u_ff;

endmodule

### rtl/core/gnz_lookup.sv
module gnz_lookup
   import gnz_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 in_valid,
   input  load_type             ld,
   input  logic [TAB_BITS-1:0]  cx,
   input  logic [TAB_BITS-1:0]  cy,
   input  logic [FADE_BITS-1:0] fx,
   input  logic [FADE_BITS-1:0] fy,
   output logic                 out_valid,
   output grad_type             g_aa,
   output grad_type             g_ba,
   output grad_type             g_ab,
   output grad_type             g_bb,
   output logic [FADE_BITS-1:0] out_fx,
   output logic [FADE_BITS-1:0] out_fy
);

   // table copies, each written as a load passes the stage that reads it
   logic [TAB_BITS-1:0] perm_l1 [TAB_DEPTH];
   logic [TAB_BITS-1:0] perm_la [TAB_DEPTH];
   logic [TAB_BITS-1:0] perm_lb [TAB_DEPTH];
   grad_type            grad_l0 [TAB_DEPTH];
   grad_type            grad_l1 [TAB_DEPTH];

   logic v1_ff, v2_ff, v3_ff;
   load_type ld1_ff, ld2_ff;
   logic [1:0] op3_ff;
   logic [TAB_BITS-1:0] pa1_ff, pb1_ff, cy1_ff;
   logic [TAB_BITS-1:0] aa2_ff, ab2_ff, ba2_ff, bb2_ff;
   logic [FADE_BITS-1:0] fx1_ff, fy1_ff, fx2_ff, fy2_ff, fx3_ff, fy3_ff;
   grad_type gaa_ff, gba_ff, gab_ff, gbb_ff;

   logic [TAB_BITS-1:0] a_w, b_w;

   always_comb begin
      a_w = pa1_ff + cy1_ff;
      b_w = pb1_ff + cy1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (in_valid && ld.op == OP_PERM) begin
            perm_l1[ld.idx] <= ld.perm;
         end
         pa1_ff <= perm_l1[cx];
         pb1_ff <= perm_l1[TAB_BITS'(cx + 1'b1)];
         cy1_ff <= cy;
         fx1_ff <= fx;
         fy1_ff <= fy;
         ld1_ff <= ld;

         if (v1_ff && ld1_ff.op == OP_PERM) begin
            perm_la[ld1_ff.idx] <= ld1_ff.perm;
            perm_lb[ld1_ff.idx] <= ld1_ff.perm;
         end
         aa2_ff <= perm_la[a_w];
         ab2_ff <= perm_la[TAB_BITS'(a_w + 1'b1)];
         ba2_ff <= perm_lb[b_w];
         bb2_ff <= perm_lb[TAB_BITS'(b_w + 1'b1)];
         fx2_ff <= fx1_ff;
         fy2_ff <= fy1_ff;
         ld2_ff <= ld1_ff;

         if (v2_ff && ld2_ff.op == OP_GRAD) begin
            grad_l0[ld2_ff.idx] <= ld2_ff.grad;
            grad_l1[ld2_ff.idx] <= ld2_ff.grad;
         end
         gaa_ff <= grad_l0[aa2_ff];
         gba_ff <= grad_l0[ba2_ff];
         gab_ff <= grad_l1[ab2_ff];
         gbb_ff <= grad_l1[bb2_ff];
         fx3_ff <= fx2_ff;
         fy3_ff <= fy2_ff;
         op3_ff <= ld2_ff.op;
      end
   end

   assign out_valid = v3_ff && (op3_ff == OP_EVAL);
   assign g_aa      = gaa_ff;
   assign g_ba      = gba_ff;
   assign g_ab      = gab_ff;
   assign g_bb      = gbb_ff;
   assign out_fx    = fx3_ff;
   assign out_fy    = fy3_ff;

endmodule

### rtl/core/gnz_blend.sv
module gnz_blend
   import gnz_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 in_valid,
   input  grad_type             g_aa,
   input  grad_type             g_ba,
   input  grad_type             g_ab,
   input  grad_type             g_bb,
   input  logic [FADE_BITS-1:0] fx,
   input  logic [FADE_BITS-1:0] fy,
   input  logic [FADE_BITS-1:0] u,
   input  logic [FADE_BITS-1:0] v,
   output logic                 out_valid,
   output logic [OUT_BITS-1:0]  out_noise
);

   logic [5:0] vld_ff;

   logic signed [FADE_BITS:0] dx0, dx1, dy0, dy1;
   logic signed [32:0] p_aax_ff, p_aay_ff, p_bax_ff, p_bay_ff;
   logic signed [32:0] p_abx_ff, p_aby_ff, p_bbx_ff, p_bby_ff;
   logic [FADE_BITS-1:0] u1_ff, v1_ff, u2_ff, v2_ff, v3_ff, v4_ff;

   logic signed [33:0] s_aa, s_ba, s_ab, s_bb;
   logic signed [DOT_BITS-1:0] d_aa_ff, d_ba_ff, d_ab_ff, d_bb_ff;

   logic signed [DOT_BITS:0] dl_w, dh_w;
   logic signed [37:0] ml_ff, mh_ff;
   logic signed [DOT_BITS-1:0] la_ff, ha_ff;

   logic signed [37:0] lo_w, hi_w;
   logic signed [DOT_BITS-1:0] lo_ff, hi_ff;

   logic signed [DOT_BITS:0] dv_w;
   logic signed [37:0] mv_ff;
   logic signed [DOT_BITS-1:0] lo5_ff;

   logic signed [37:0] r_w;
   logic signed [DOT_BITS-1:0] r_s;
   logic [OUT_BITS-1:0] noise_ff;

   always_comb begin
      // far corner offset is the fraction minus one: same low bits, sign set
      dx0 = $signed({1'b0, fx});
      dx1 = $signed({1'b1, fx});
      dy0 = $signed({1'b0, fy});
      dy1 = $signed({1'b1, fy});

      s_aa = 34'(p_aax_ff) + 34'(p_aay_ff);
      s_ba = 34'(p_bax_ff) + 34'(p_bay_ff);
      s_ab = 34'(p_abx_ff) + 34'(p_aby_ff);
      s_bb = 34'(p_bbx_ff) + 34'(p_bby_ff);

      dl_w = (DOT_BITS+1)'(d_ba_ff) - (DOT_BITS+1)'(d_aa_ff);
      dh_w = (DOT_BITS+1)'(d_bb_ff) - (DOT_BITS+1)'(d_ab_ff);

      lo_w = 38'(la_ff) + (ml_ff >>> FADE_BITS);
      hi_w = 38'(ha_ff) + (mh_ff >>> FADE_BITS);

      dv_w = (DOT_BITS+1)'(hi_ff) - (DOT_BITS+1)'(lo_ff);

      r_w = 38'(lo5_ff) + (mv_ff >>> FADE_BITS);
      r_s = r_w[DOT_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[4:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_aax_ff <= 33'(g_aa.gx) * 33'(dx0);
         p_aay_ff <= 33'(g_aa.gy) * 33'(dy0);
         p_bax_ff <= 33'(g_ba.gx) * 33'(dx1);
         p_bay_ff <= 33'(g_ba.gy) * 33'(dy0);
         p_abx_ff <= 33'(g_ab.gx) * 33'(dx0);
         p_aby_ff <= 33'(g_ab.gy) * 33'(dy1);
         p_bbx_ff <= 33'(g_bb.gx) * 33'(dx1);
         p_bby_ff <= 33'(g_bb.gy) * 33'(dy1);
         u1_ff    <= u;
         v1_ff    <= v;

         d_aa_ff <= DOT_BITS'(s_aa >>> (GRAD_BITS - 1));
         d_ba_ff <= DOT_BITS'(s_ba >>> (GRAD_BITS - 1));
         d_ab_ff <= DOT_BITS'(s_ab >>> (GRAD_BITS - 1));
         d_bb_ff <= DOT_BITS'(s_bb >>> (GRAD_BITS - 1));
         u2_ff   <= u1_ff;
         v2_ff   <= v1_ff;

         ml_ff <= 38'($signed({1'b0, u2_ff})) * 38'(dl_w);
         mh_ff <= 38'($signed({1'b0, u2_ff})) * 38'(dh_w);
         la_ff <= d_aa_ff;
         ha_ff <= d_ab_ff;
         v3_ff <= v2_ff;

         lo_ff <= lo_w[DOT_BITS-1:0];
         hi_ff <= hi_w[DOT_BITS-1:0];
         v4_ff <= v3_ff;

         mv_ff  <= 38'($signed({1'b0, v4_ff})) * 38'(dv_w);
         lo5_ff <= lo_ff;

         if (r_s > OUT_MAX) begin
            noise_ff <= OUT_MAX[OUT_BITS-1:0];
         end else if (r_s < OUT_MIN) begin
            noise_ff <= OUT_MIN[OUT_BITS-1:0];
         end else begin
            noise_ff <= r_s[OUT_BITS-1:0];
         end
      end
   end

   assign out_valid = vld_ff[5];
   assign out_noise = noise_ff;

endmodule

### rtl/core/gradient_noise_2d_core.sv
// 2D improved gradient noise over signed Q16.16 coordinates, result signed
// Q2.16 saturated. One item enters per cycle while req_stall is low; an
// evaluate item gives one result, load items give none. The permutation
// and gradient tables are held in replicated RAM copies, each written as a
// load item passes the stage that reads it, so every item sees the tables
// exactly as they were when it was accepted. Software must load every entry
// an evaluate touches before issuing it. A two-entry output buffer lets the
// pipeline keep moving until a second result meets rsp_stall; req_stall
// rises only while both entries are full.
module gradient_noise_2d_core
   import gnz_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_op,
   input  logic [TAB_BITS-1:0]          req_entry_index,
   input  logic [TAB_BITS-1:0]          req_perm_value,
   input  logic signed [GRAD_BITS-1:0]  req_grad_x,
   input  logic signed [GRAD_BITS-1:0]  req_grad_y,
   input  logic signed [COORD_BITS-1:0] req_coord_x,
   input  logic signed [COORD_BITS-1:0] req_coord_y,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [OUT_BITS-1:0]   rsp_noise_value
);

   logic adv;
   logic r0_valid_ff;
   load_type r0_ld_ff;
   logic [TAB_BITS-1:0] r0_cx_ff, r0_cy_ff;
   logic [FADE_BITS-1:0] r0_fx_ff, r0_fy_ff;

   logic lk_valid;
   grad_type g_aa, g_ba, g_ab, g_bb;
   logic [FADE_BITS-1:0] lk_fx, lk_fy, fade_u, fade_v;
   logic bl_valid;
   logic [OUT_BITS-1:0] bl_noise;

   logic out_valid_ff, skid_valid_ff, out_free;
   logic [OUT_BITS-1:0] out_data_ff, skid_data_ff;

   assign adv       = !skid_valid_ff;
   assign req_stall = skid_valid_ff;
   assign out_free  = !out_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         r0_valid_ff <= 1'b0;
      end else if (adv) begin
         r0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         r0_ld_ff.op   <= req_op;
         r0_ld_ff.idx  <= req_entry_index;
         r0_ld_ff.perm <= req_perm_value;
         r0_ld_ff.grad <= '{gx: req_grad_x, gy: req_grad_y};
         r0_cx_ff      <= req_coord_x[FRAC_BITS+TAB_BITS-1:FRAC_BITS];
         r0_cy_ff      <= req_coord_y[FRAC_BITS+TAB_BITS-1:FRAC_BITS];
         r0_fx_ff      <= req_coord_x[FRAC_BITS-1:0];
         r0_fy_ff      <= req_coord_y[FRAC_BITS-1:0];
      end
   end

   gnz_lookup u_lookup (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (r0_valid_ff),
      .ld        (r0_ld_ff),
      .cx        (r0_cx_ff),
      .cy        (r0_cy_ff),
      .fx        (r0_fx_ff),
      .fy        (r0_fy_ff),
      .out_valid (lk_valid),
      .g_aa      (g_aa),
      .g_ba      (g_ba),
      .g_ab      (g_ab),
      .g_bb      (g_bb),
      .out_fx    (lk_fx),
      .out_fy    (lk_fy)
   );

   gnz_fade u_fade_x (
      .clock (clock),
      .adv   (adv),
      .t     (r0_fx_ff),
      .u     (fade_u)
   );

   gnz_fade u_fade_y (
      .clock (clock),
      .adv   (adv),
      .t     (r0_fy_ff),
      .u     (fade_v)
   );

   gnz_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (lk_valid),
      .g_aa      (g_aa),
      .g_ba      (g_ba),
      .g_ab      (g_ab),
      .g_bb      (g_bb),
      .fx        (lk_fx),
      .fy        (lk_fy),
      .u         (fade_u),
      .v         (fade_v),
      .out_valid (bl_valid),
      .out_noise (bl_noise)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_free) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (bl_valid) begin
         if (out_free) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (out_free) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (out_free) begin
            out_data_ff <= skid_data_ff;
         end
      end else if (bl_valid) begin
         if (out_free) begin
            out_data_ff <= bl_noise;
         end else begin
            skid_data_ff <= bl_noise;
         end
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_noise_value = $signed(out_data_ff);

endmodule

### rtl/core/gnz_chk.sv
module gnz_chk
   import gnz_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic signed [OUT_BITS-1:0] rsp_noise_value
);

   // a held result stays put until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_noise_value))
      else $error("stalled item changed or dropped");

   // backpressure only while a result is waiting
   a_stall_needs_rsp: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("req_stall without a pending item");

   a_stall_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(rsp_valid && rsp_stall))
      else $error("req_stall rose without rsp_stall");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("outputs not cleared by reset");

   a_stall_release: assert property (@(posedge clock) disable iff (reset)
      req_stall && !rsp_stall |=> !req_stall)
      else $error("req_stall held after output drained");

endmodule

bind gradient_noise_2d_core gnz_chk u_gnz_chk (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_noise_value (rsp_noise_value)
);
